[src/ttb_pkg.sv]
// Package for the triangle tangent basis block: default widths, step codes
// and the controller/datapath command and status types. No dependencies.
package ttb_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_INDEX_WIDTH = 16;
    localparam int LIMIT_WIDTH     = 31;

    // Product pairs, worked in this order
    localparam logic [2:0] PAIR_DET = 3'd0;
    localparam logic [2:0] PAIR_TX  = 3'd1;
    localparam logic [2:0] PAIR_TY  = 3'd2;
    localparam logic [2:0] PAIR_TZ  = 3'd3;
    localparam logic [2:0] PAIR_BX  = 3'd4;
    localparam logic [2:0] PAIR_BY  = 3'd5;
    localparam logic [2:0] PAIR_BZ  = 3'd6;

    typedef struct packed {
        logic       load_c0;
        logic       load_c1;
        logic       load_c2;
        logic       diff;
        logic       mul_a;
        logic       mul_b;
        logic       sub;
        logic       abs_det;
        logic       check;
        logic       div_start;
        logic       store_res;
        logic       load_fallback;
        logic       load_out;
        logic [2:0] pair;
        logic [1:0] out_sel;
    } ttb_cmd_t;

    typedef struct packed {
        logic degen;
        logic div_done;
    } ttb_sts_t;

endpackage

[src/ttb_div.sv]
// Bit-serial restoring divider: (|num| << FRAC_BITS) / |den|, signed and
// saturated to COORD_WIDTH bits. Uses ttb_pkg.
module ttb_div
    import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int NUM_WIDTH   = 2 * DEF_COORD_WIDTH + 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [NUM_WIDTH-1:0] num,
    input  logic        [NUM_WIDTH-1:0] den_abs,
    input  logic                        den_neg,
    output logic                        done,
    output logic        [COORD_WIDTH-1:0] quo
);
    localparam int W   = COORD_WIDTH;
    localparam int NW  = NUM_WIDTH;
    localparam int QW  = NW + FRAC_BITS;
    localparam int CTW = $clog2(QW + 1);
    localparam logic [QW-1:0] LIM_P = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0] LIM_N = LIM_P + QW'(1);
    localparam logic [W-1:0]  MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINNEG = {1'b1, {(W-1){1'b0}}};

    logic [QW-1:0]  q_reg;
    logic [NW-1:0]  rem_reg;
    logic [NW-1:0]  den_reg;
    logic           neg_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [CTW-1:0] cnt_reg;
    logic [W-1:0]   quo_reg;

    logic [NW-1:0]  num_abs;
    logic [NW:0]    rem_sh;
    logic           ge;
    logic [NW:0]    rem_sub;
    logic           over;

    assign num_abs = num[NW-1] ? $unsigned(-num) : $unsigned(num);
    assign rem_sh  = {rem_reg, q_reg[QW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign over    = neg_reg ? (q_reg > LIM_N) : (q_reg > LIM_P);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= {num_abs, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den_abs;
            neg_reg <= num[NW-1] ^ den_neg;
            cnt_reg <= CTW'(QW);
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
                q_reg   <= {q_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - CTW'(1);
            end else begin
                if (neg_reg) begin
                    quo_reg <= over ? MINNEG : -q_reg[W-1:0];
                end else begin
                    quo_reg <= over ? MAXPOS : q_reg[W-1:0];
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[src/ttb_datapath.sv]
// Datapath: corner holding registers, edge and UV deltas, one shared
// multiplier, degenerate check, result and output buffers. Uses ttb_pkg, ttb_div.
module ttb_datapath
    import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ttb_cmd_t                          cmd,
    output ttb_sts_t                          sts,
    input  logic                              cfg_wr_en,
    input  logic [LIMIT_WIDTH-1:0]            cfg_wr_data,
    input  logic [2:0][COORD_WIDTH-1:0]       in_pos,
    input  logic [1:0][COORD_WIDTH-1:0]       in_tex,
    input  logic [2:0][COORD_WIDTH-1:0]       in_norm,
    input  logic [INDEX_WIDTH-1:0]            in_index,
    output logic [INDEX_WIDTH-1:0]            o_index,
    output logic [2:0][COORD_WIDTH-1:0]       o_tan,
    output logic [2:0][COORD_WIDTH-1:0]       o_bitan,
    output logic                              o_degen
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE    = (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : MAXPOS;

    logic [2:0][W-1:0]   pos0_reg, pos1_reg, pos2_reg, norm_reg;
    logic [1:0][W-1:0]   tex0_reg, tex1_reg, tex2_reg;
    logic [2:0][INDEX_WIDTH-1:0] idx_reg;
    logic [LIMIT_WIDTH-1:0] limit_reg;

    logic signed [2:0][DW-1:0] e1_reg, e2_reg;
    logic signed [DW-1:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;

    logic signed [DW-1:0] ma0, mb0, ma1, mb1, mx, my;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    logic signed [NW-1:0] num_reg;
    logic        [NW-1:0] dabs_reg;
    logic                 dneg_reg;
    logic                 degen_reg;

    logic                 div_done;
    logic [W-1:0]         div_quo;

    logic [2:0][W-1:0]    tan_reg, bit_reg;
    logic [2:0][INDEX_WIDTH-1:0] obuf_idx_reg;
    logic [2:0][W-1:0]    obuf_tan_reg, obuf_bit_reg;
    logic                 obuf_degen_reg;

    function automatic logic signed [DW-1:0] sdiff(input logic [W-1:0] a, input logic [W-1:0] b);
        sdiff = $signed({a[W-1], a}) - $signed({b[W-1], b});
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_c0) begin
            pos0_reg   <= in_pos;
            tex0_reg   <= in_tex;
            norm_reg   <= in_norm;
            idx_reg[0] <= in_index;
        end
        if (cmd.load_c1) begin
            pos1_reg   <= in_pos;
            tex1_reg   <= in_tex;
            idx_reg[1] <= in_index;
        end
        if (cmd.load_c2) begin
            pos2_reg   <= in_pos;
            tex2_reg   <= in_tex;
            idx_reg[2] <= in_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            for (int c = 0; c < 3; c++) begin
                e1_reg[c] <= sdiff(pos1_reg[c], pos0_reg[c]);
                e2_reg[c] <= sdiff(pos2_reg[c], pos0_reg[c]);
            end
            d1u_reg <= sdiff(tex1_reg[0], tex0_reg[0]);
            d1v_reg <= sdiff(tex1_reg[1], tex0_reg[1]);
            d2u_reg <= sdiff(tex2_reg[0], tex0_reg[0]);
            d2v_reg <= sdiff(tex2_reg[1], tex0_reg[1]);
        end
    end

    always_comb begin
        case (cmd.pair)
            PAIR_DET: begin ma0 = d1u_reg; mb0 = d2v_reg; ma1 = d2u_reg; mb1 = d1v_reg; end
            PAIR_TX:  begin ma0 = d2v_reg; mb0 = e1_reg[0]; ma1 = d1v_reg; mb1 = e2_reg[0]; end
            PAIR_TY:  begin ma0 = d2v_reg; mb0 = e1_reg[1]; ma1 = d1v_reg; mb1 = e2_reg[1]; end
            PAIR_TZ:  begin ma0 = d2v_reg; mb0 = e1_reg[2]; ma1 = d1v_reg; mb1 = e2_reg[2]; end
            PAIR_BX:  begin ma0 = d1u_reg; mb0 = e2_reg[0]; ma1 = d2u_reg; mb1 = e1_reg[0]; end
            PAIR_BY:  begin ma0 = d1u_reg; mb0 = e2_reg[1]; ma1 = d2u_reg; mb1 = e1_reg[1]; end
            PAIR_BZ:  begin ma0 = d1u_reg; mb0 = e2_reg[2]; ma1 = d2u_reg; mb1 = e1_reg[2]; end
            default:  begin ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0; end
        endcase
        mx = cmd.mul_b ? ma1 : ma0;
        my = cmd.mul_b ? mb1 : mb0;
    end

    assign prod = mx * my;

    always_ff @(posedge aclk) begin
        if (cmd.mul_a) begin
            prod_a_reg <= prod;
        end
        if (cmd.mul_b) begin
            prod_b_reg <= prod;
        end
        if (cmd.sub) begin
            num_reg <= $signed({prod_a_reg[PW-1], prod_a_reg})
                     - $signed({prod_b_reg[PW-1], prod_b_reg});
        end
        if (cmd.abs_det) begin
            dabs_reg <= num_reg[NW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
            dneg_reg <= num_reg[NW-1];
        end
        if (cmd.check) begin
            degen_reg <= (({{LIMIT_WIDTH{1'b0}}, dabs_reg} >> FRAC_BITS)
                          <= {{NW{1'b0}}, limit_reg});
        end
    end

    ttb_div #(
        .COORD_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS),
        .NUM_WIDTH   (NW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den_abs (dabs_reg),
        .den_neg (dneg_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.store_res) begin
            case (cmd.pair)
                PAIR_TX: tan_reg[0] <= div_quo;
                PAIR_TY: tan_reg[1] <= div_quo;
                PAIR_TZ: tan_reg[2] <= div_quo;
                PAIR_BX: bit_reg[0] <= div_quo;
                PAIR_BY: bit_reg[1] <= div_quo;
                PAIR_BZ: bit_reg[2] <= div_quo;
                default: ;
            endcase
        end else if (cmd.load_fallback) begin
            tan_reg[0] <= ONE;
            tan_reg[1] <= '0;
            tan_reg[2] <= '0;
            bit_reg[0] <= '0;
            bit_reg[1] <= norm_reg[2];
            bit_reg[2] <= (norm_reg[1] == MINNEG) ? MAXPOS : -norm_reg[1];
        end
        if (cmd.load_out) begin
            obuf_idx_reg   <= idx_reg;
            obuf_tan_reg   <= tan_reg;
            obuf_bit_reg   <= bit_reg;
            obuf_degen_reg <= degen_reg;
        end
    end

    always_comb begin
        case (cmd.out_sel)
            2'd0:    o_index = obuf_idx_reg[0];
            2'd1:    o_index = obuf_idx_reg[1];
            default: o_index = obuf_idx_reg[2];
        endcase
    end

    assign o_tan        = obuf_tan_reg;
    assign o_bitan      = obuf_bit_reg;
    assign o_degen      = obuf_degen_reg;
    assign sts.degen    = degen_reg;
    assign sts.div_done = div_done;

endmodule

[src/ttb_ctrl.sv]
// Controller: corner collection, product/divide sequencing and the output
// item counter. Drives the datapath through ttb_cmd_t. Uses ttb_pkg.
module ttb_ctrl
    import ttb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output logic     m_last,
    output ttb_cmd_t cmd,
    input  ttb_sts_t sts
);
    localparam logic [3:0] S_C0    = 4'd0;
    localparam logic [3:0] S_C1    = 4'd1;
    localparam logic [3:0] S_C2    = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_MULA  = 4'd4;
    localparam logic [3:0] S_MULB  = 4'd5;
    localparam logic [3:0] S_SUB   = 4'd6;
    localparam logic [3:0] S_ABS   = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_DEC   = 4'd9;
    localparam logic [3:0] S_DIVGO = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_WOUT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] pair_reg, pair_next;
    logic       obusy_reg, obusy_next;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       m_fire;

    assign s_ready = (state_reg == S_C0) || (state_reg == S_C1) || (state_reg == S_C2);
    assign m_valid = obusy_reg;
    assign m_last  = (ocnt_reg == 2'd2);
    assign m_fire  = obusy_reg && m_ready;

    always_comb begin
        state_next = state_reg;
        pair_next  = pair_reg;
        obusy_next = obusy_reg;
        ocnt_next  = ocnt_reg;
        cmd        = '0;
        cmd.pair   = pair_reg;
        cmd.out_sel = ocnt_reg;

        if (m_fire) begin
            if (ocnt_reg == 2'd2) begin
                obusy_next = 1'b0;
            end else begin
                ocnt_next = ocnt_reg + 2'd1;
            end
        end

        case (state_reg)
            S_C0: begin
                if (s_valid) begin
                    cmd.load_c0 = 1'b1;
                    state_next = S_C1;
                end
            end
            S_C1: begin
                if (s_valid) begin
                    cmd.load_c1 = 1'b1;
                    state_next = S_C2;
                end
            end
            S_C2: begin
                if (s_valid) begin
                    cmd.load_c2 = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                pair_next  = PAIR_DET;
                state_next = S_MULA;
            end
            S_MULA: begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB: begin
                cmd.mul_b  = 1'b1;
                state_next = S_SUB;
            end
            S_SUB: begin
                cmd.sub    = 1'b1;
                state_next = (pair_reg == PAIR_DET) ? S_ABS : S_DIVGO;
            end
            S_ABS: begin
                cmd.abs_det = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK: begin
                cmd.check  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                if (sts.degen) begin
                    cmd.load_fallback = 1'b1;
                    state_next = S_WOUT;
                end else begin
                    pair_next  = PAIR_TX;
                    state_next = S_MULA;
                end
            end
            S_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.store_res = 1'b1;
                    if (pair_reg == PAIR_BZ) begin
                        state_next = S_WOUT;
                    end else begin
                        pair_next  = pair_reg + 3'd1;
                        state_next = S_MULA;
                    end
                end
            end
            S_WOUT: begin
                if (!obusy_reg) begin
                    cmd.load_out = 1'b1;
                    obusy_next   = 1'b1;
                    ocnt_next    = 2'd0;
                    state_next   = S_C0;
                end
            end
            default: begin
                state_next = S_C0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_C0;
            pair_reg  <= PAIR_DET;
            obusy_reg <= 1'b0;
            ocnt_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            pair_reg  <= pair_next;
            obusy_reg <= obusy_next;
            ocnt_reg  <= ocnt_next;
        end
    end

endmodule

[src/triangle_tangent_basis.sv]
// Triangle tangent basis: top level, stream ports and field packing.
// Uses ttb_pkg, ttb_ctrl, ttb_datapath.
//
// Corners enter on s_axis one item each; every third corner closes a triangle.
// The first two corners are only held in corner registers. The third starts the
// computation: deltas, the determinant and, unless the UV mapping is
// degenerate, six quotients from one bit-serial divider of
// 2*COORD_WIDTH+3+FRAC_BITS steps each (Q16.16 coordinates by default).
// s_axis_tready stays low while a triangle is worked on and until its results
// are loaded into the output buffer.
// Three result items, one per corner index, then leave on m_axis, the third
// with tlast; tuser carries the degenerate flag. They sit in an output buffer,
// so the next triangle's corners are taken while m_axis is stalled; a new
// triangle only waits at its end if the previous results are not yet drained.
// cfg_wr_en/cfg_wr_data set the degenerate determinant limit (reset 0).
// Synchronous active-low reset returns to the first corner and drops m_axis_tvalid.
module triangle_tangent_basis
    import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
    localparam int S_DW = ((8 * COORD_WIDTH + INDEX_WIDTH + 7) / 8) * 8,
    localparam int M_DW = ((6 * COORD_WIDTH + INDEX_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_WIDTH-1:0] cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z, vertex_index
    input  logic [S_DW-1:0]        s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_index, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z
    output logic [M_DW-1:0]        m_axis_tdata,
    // degenerate
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);
    localparam int W = COORD_WIDTH;

    ttb_cmd_t cmd;
    ttb_sts_t sts;

    logic [2:0][W-1:0]         in_pos, in_norm;
    logic [1:0][W-1:0]         in_tex;
    logic [INDEX_WIDTH-1:0]    in_index;
    logic [INDEX_WIDTH-1:0]    o_index;
    logic [2:0][W-1:0]         o_tan, o_bitan;
    logic                      o_degen;

    assign in_pos   = s_axis_tdata[3*W-1:0];
    assign in_tex   = s_axis_tdata[5*W-1:3*W];
    assign in_norm  = s_axis_tdata[8*W-1:5*W];
    assign in_index = s_axis_tdata[8*W+INDEX_WIDTH-1:8*W];

    ttb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_last  (m_axis_tlast),
        .cmd     (cmd),
        .sts     (sts)
    );

    ttb_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_pos      (in_pos),
        .in_tex      (in_tex),
        .in_norm     (in_norm),
        .in_index    (in_index),
        .o_index     (o_index),
        .o_tan       (o_tan),
        .o_bitan     (o_bitan),
        .o_degen     (o_degen)
    );

    assign m_axis_tdata = M_DW'({o_bitan, o_tan, o_index});
    assign m_axis_tuser = o_degen;

endmodule

[tb/triangle_tangent_basis_tb.sv]
// Testbench for triangle_tangent_basis: directed triangles, then random ones,
// checked against a tangent basis predictor in this file. Needs the RTL.
`timescale 1ns / 100ps

module triangle_tangent_basis_tb;

    localparam int  S_DW       = 272;
    localparam int  M_DW       = 208;
    localparam int  MAX_CYCLES = 2000000;
    localparam int  NUM_RAND   = 410;
    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] tex [2];
        logic signed [31:0] nrm [3];
        logic [15:0]        vidx;
    } corner_t;

    typedef struct packed {
        logic [15:0] vidx;
        logic [31:0] tan_x, tan_y, tan_z;
        logic [31:0] bit_x, bit_y, bit_z;
        logic        degen;
        logic        last;
    } basis_t;

    typedef struct {
        corner_t c;
        bit      typed;
        basis_t  want;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [30:0]       cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [S_DW-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [M_DW-1:0]   m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              m_axis_tlast;

    triangle_tangent_basis u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    basis_t    basis_q[$];
    corner_t   held[2];
    int        held_cnt;
    logic [30:0] degen_limit;
    int        errors;
    int        cycles;
    int        rx_wait;
    bit        no_idle;
    int        n_tri, n_degen, n_res;
    stim_row_t rows[$];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("[triangle_tangent_basis] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] fix_div(logic signed [127:0] num,
                                            logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< 16) / den;
        if (q > Q_MAX) return 32'h7fff_ffff;
        if (q < Q_MIN) return 32'h8000_0000;
        return q[31:0];
    endfunction

    // Basis for the triangle closed by c2, using the two held corners.
    function automatic basis_t tangent_basis(corner_t c2);
        logic signed [127:0] e1 [3];
        logic signed [127:0] e2 [3];
        logic signed [127:0] d1u, d1v, d2u, d2v, det, mag;
        basis_t b;
        logic [31:0] t [3];
        logic [31:0] bt [3];
        for (int k = 0; k < 3; k++) begin
            e1[k] = 128'(held[1].pos[k]) - 128'(held[0].pos[k]);
            e2[k] = 128'(c2.pos[k]) - 128'(held[0].pos[k]);
        end
        d1u = 128'(held[1].tex[0]) - 128'(held[0].tex[0]);
        d1v = 128'(held[1].tex[1]) - 128'(held[0].tex[1]);
        d2u = 128'(c2.tex[0]) - 128'(held[0].tex[0]);
        d2v = 128'(c2.tex[1]) - 128'(held[0].tex[1]);
        det = d1u * d2v - d2u * d1v;
        mag = (det < 0) ? -det : det;
        b = '0;
        b.degen = ((mag >>> 16) <= 128'(degen_limit));
        if (b.degen) begin
            b.tan_x = 32'h0001_0000;
            b.bit_y = held[0].nrm[2];
            b.bit_z = (held[0].nrm[1] == 32'h8000_0000) ? 32'h7fff_ffff
                                                        : -held[0].nrm[1];
        end else begin
            for (int k = 0; k < 3; k++) begin
                t[k]  = fix_div(d2v * e1[k] - d1v * e2[k], det);
                bt[k] = fix_div(d1u * e2[k] - d2u * e1[k], det);
            end
            {b.tan_x, b.tan_y, b.tan_z} = {t[0], t[1], t[2]};
            {b.bit_x, b.bit_y, b.bit_z} = {bt[0], bt[1], bt[2]};
        end
        return b;
    endfunction

    function automatic logic [S_DW-1:0] pack_corner(corner_t c);
        return {c.vidx, c.nrm[2], c.nrm[1], c.nrm[0], c.tex[1], c.tex[0],
                c.pos[2], c.pos[1], c.pos[0]};
    endfunction

    // Corner taken: hold it, or close the triangle and queue three results.
    task automatic corner_accepted(corner_t c, bit typed, basis_t want);
        basis_t b;
        logic [15:0] ids [3];
        if (held_cnt < 2) begin
            held[held_cnt] = c;
            held_cnt++;
        end else begin
            b = typed ? want : tangent_basis(c);
            ids[0] = held[0].vidx;
            ids[1] = held[1].vidx;
            ids[2] = c.vidx;
            for (int k = 0; k < 3; k++) begin
                b.vidx = ids[k];
                b.last = (k == 2);
                basis_q = {basis_q, b};
            end
            n_tri++;
            if (b.degen) n_degen++;
            held_cnt = 0;
        end
    endtask

    task automatic send_corner(corner_t c, bit typed, basis_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_corner(c);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        corner_accepted(c, typed, want);
        @(negedge aclk);
    endtask

    task automatic set_limit(logic [30:0] v);
        s_axis_tvalid <= 1'b0;
        while (basis_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        degen_limit = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1, 2:    return $urandom_range(0, 1 << 19) - (1 << 18);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    function automatic corner_t rand_corner();
        corner_t c;
        for (int k = 0; k < 3; k++) c.pos[k] = rand_coord();
        for (int k = 0; k < 2; k++) c.tex[k] = rand_coord();
        for (int k = 0; k < 3; k++) c.nrm[k] = rand_coord();
        c.vidx = 16'($urandom());
        return c;
    endfunction

    function automatic corner_t mk(int px, int py, int pz, int tu, int tv,
                                   int nx, int ny, int nz, int vi);
        corner_t c;
        c.pos[0] = px; c.pos[1] = py; c.pos[2] = pz;
        c.tex[0] = tu; c.tex[1] = tv;
        c.nrm[0] = nx; c.nrm[1] = ny; c.nrm[2] = nz;
        c.vidx = 16'(vi);
        return c;
    endfunction

    task automatic add_row(corner_t c, bit typed = 1'b0, basis_t want = '0);
        stim_row_t r;
        r.c = c;
        r.typed = typed;
        r.want = want;
        rows = {rows, r};
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h got %h", name, want, got);
        end
    endtask

    // Result monitor and receiver stall control
    always @(posedge aclk) begin
        basis_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[79:48],
                   m_axis_tdata[111:80], m_axis_tdata[143:112], m_axis_tdata[175:144],
                   m_axis_tdata[207:176], m_axis_tuser[0], m_axis_tlast};
            n_res++;
            rx_wait <= no_idle ? 0 : $urandom_range(0, 16);
            if (basis_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
            end else begin
                want = basis_q.pop_front();
                check_field("out_index", 32'(want.vidx), 32'(got.vidx));
                check_field("tan_x", want.tan_x, got.tan_x);
                check_field("tan_y", want.tan_y, got.tan_y);
                check_field("tan_z", want.tan_z, got.tan_z);
                check_field("bitan_x", want.bit_x, got.bit_x);
                check_field("bitan_y", want.bit_y, got.bit_y);
                check_field("bitan_z", want.bit_z, got.bit_z);
                check_field("degenerate", 32'(want.degen), 32'(got.degen));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        basis_t fb;
        localparam int ONE = 32'h0001_0000;
        localparam int MX  = 32'h7fff_ffff;
        localparam int MN  = 32'h8000_0000;
        errors = 0; cycles = 0; rx_wait = 0; no_idle = 0;
        n_tri = 0; n_degen = 0; n_res = 0; held_cnt = 0; degen_limit = '0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // zero UV area, extreme normal: fallback basis with saturated bitangent
        fb = '0;
        fb.tan_x = ONE; fb.bit_y = MX; fb.bit_z = MX; fb.degen = 1'b1;
        add_row(mk(0, 0, 0, 0, 0, MN, MN, MX, 0));
        add_row(mk(ONE, 0, 0, 0, 0, MX, MX, MN, 65535));
        add_row(mk(0, ONE, 0, 0, 0, 0, 0, 0, 1), 1'b1, fb);
        // unit right triangle with matching UVs
        add_row(mk(0, 0, 0, 0, 0, 0, 0, ONE, 10));
        add_row(mk(ONE, 0, 0, ONE, 0, 0, 0, ONE, 11));
        add_row(mk(0, ONE, 0, 0, ONE, 0, 0, ONE, 12));
        // extreme positions, small UVs: determinant below one LSB, degenerate at limit 0
        add_row(mk(MN, MN, MN, 0, 0, ONE, 0, 0, 65535));
        add_row(mk(MX, MX, MX, 1, 0, ONE, 0, 0, 0));
        add_row(mk(MX, MN, MX, 0, 2, ONE, 0, 0, 65534));
        // extreme texture coordinates, huge determinant
        add_row(mk(0, 0, 0, MN, MN, 0, ONE, 0, 100));
        add_row(mk(ONE, ONE, 0, MX, MN, 0, ONE, 0, 101));
        add_row(mk(0, ONE, ONE, MN, MX, 0, ONE, 0, 102));
        // mirrored UVs, negative determinant
        add_row(mk(0, 0, 0, 0, 0, 0, 0, -ONE, 200));
        add_row(mk(3 * ONE, 0, -ONE, 0, ONE, 0, 0, -ONE, 201));
        add_row(mk(0, 2 * ONE, ONE, ONE, 0, 0, 0, -ONE, 202));
        // determinant just under one LSB after truncation: degenerate at limit 0
        add_row(mk(0, 0, 0, 0, 0, 5, -7, 9, 300));
        add_row(mk(ONE, 0, 0, 1, 0, 5, -7, 9, 301));
        add_row(mk(0, ONE, 0, 0, 1, 5, -7, 9, 302));
        // determinant exactly one LSB: normal case
        add_row(mk(-ONE, 0, 0, 0, 0, 0, 0, 0, 400));
        add_row(mk(ONE, ONE, 0, 256, 0, 0, 0, 0, 401));
        add_row(mk(0, 0, ONE, 0, 256, 0, 0, 0, 402));

        set_limit(31'd0);
        foreach (rows[i]) send_corner(rows[i].c, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_limit(31'h7fff_ffff);
                1: set_limit(31'd32);
                2: set_limit(31'($urandom_range(0, 1 << 20)));
                default: set_limit(31'd0);
            endcase
            for (int i = 0; i < NUM_RAND / 4 / 3 * 3; i++) begin
                if (i % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_corner(rand_corner(), 1'b0, '0);
            end
            no_idle = 0;
        end

        s_axis_tvalid <= 1'b0;
        while (basis_q.size() != 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
        $display("covered %0d triangles (%0d degenerate), %0d result items checked",
                 n_tri, n_degen, n_res);
        $display("limits 0, 32, max and a random value; %0d mismatches", errors);
        if (errors == 0 && basis_q.size() == 0) begin
            $display("[triangle_tangent_basis] OK");
        end else begin
            $display("[triangle_tangent_basis] ERROR");
        end
        $finish;
    end

endmodule
